[rtl/ard_pkg.sv]
package ard_pkg;

  // Field widths fixed by the frame format
  localparam int FieldWidth    = 62;
  localparam int DelayWidth    = 64;
  localparam int KindWidth     = 2;
  localparam int ExpWidth      = 5;
  localparam int MulWidth      = 20;
  localparam int CfgIdxWidth   = 1;
  localparam int CfgDataWidth  = 20;
  localparam int HalfWidth     = DelayWidth / 2;

  // Default for the usable width of a field value
  localparam int ValueWidthDef = 62;

  // A gap field encodes one less than the number of skipped packets, plus one
  localparam int GapOffset     = 2;

  // Result kinds
  localparam logic [KindWidth-1:0] KindDelay = 2'd0;
  localparam logic [KindWidth-1:0] KindRange = 2'd1;
  localparam logic [KindWidth-1:0] KindError = 2'd2;

  // Error codes
  localparam logic ErrFirstBlock = 1'b0;
  localparam logic ErrLaterRange = 1'b1;

  // Configuration register indexes
  localparam logic [CfgIdxWidth-1:0] CfgDelayExponent = 1'd0;
  localparam logic [CfgIdxWidth-1:0] CfgTimeUnits     = 1'd1;

  // Reset values of the configuration registers
  localparam logic [ExpWidth-1:0] DelayExponentRst = 5'd3;
  localparam logic [MulWidth-1:0] TimeUnitsRst     = 20'd1000;

  typedef struct packed {
    logic [FieldWidth-1:0] field_value;
    logic                  frame_start;
  } in_t;

  typedef struct packed {
    logic [KindWidth-1:0]  kind;
    logic [FieldWidth-1:0] range_low;
    logic [FieldWidth-1:0] range_high;
    logic [DelayWidth-1:0] ack_delay;
    logic                  error_code;
    logic                  last;
  } out_t;

  // Decoded result on its way to the delay scaler
  typedef struct packed {
    logic [KindWidth-1:0]  kind;
    logic [FieldWidth-1:0] range_low;
    logic [FieldWidth-1:0] range_high;
    logic                  error_code;
    logic                  last;
    logic [DelayWidth-1:0] shifted;
    logic                  shift_ovf;
  } stage_t;

endpackage

[rtl/ard_decode.sv]
module ard_decode #(
  parameter int ValueWidth = ard_pkg::ValueWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  ard_pkg::in_t                  data_i,
  output logic                          ready_o,
  input  logic [ard_pkg::ExpWidth-1:0]  delay_exponent_i,
  output logic                          stage_valid_o,
  output ard_pkg::stage_t               stage_o,
  input  logic                          stage_ready_i
);

  // Frame parser phases
  localparam logic [2:0] PhWait  = 3'd0;
  localparam logic [2:0] PhDelay = 3'd1;
  localparam logic [2:0] PhCount = 3'd2;
  localparam logic [2:0] PhFirst = 3'd3;
  localparam logic [2:0] PhGap   = 3'd4;
  localparam logic [2:0] PhBlock = 3'd5;

  // Width of the shifted delay before the overflow check
  localparam int ShiftMax = (1 << ard_pkg::ExpWidth) - 1;
  localparam int ShiftW   = (ValueWidth + ShiftMax > ard_pkg::DelayWidth + 1) ?
                            ValueWidth + ShiftMax : ard_pkg::DelayWidth + 1;

  logic [2:0]            phase_q, phase_d;
  logic [ValueWidth-1:0] bottom_q, bottom_d;
  logic [ValueWidth-1:0] top_q, top_d;
  logic [ValueWidth-1:0] left_q, left_d;
  logic                  stage_valid_q, stage_valid_d;
  ard_pkg::stage_t       stage_q, stage_d;

  logic                  take;
  logic                  has_res;
  logic [ValueWidth-1:0] v;
  logic [ValueWidth:0]   v_plus_gap;
  logic [ValueWidth-1:0] top_minus_v;
  logic [ValueWidth-1:0] left_dec;
  logic [ShiftW-1:0]     shift_full;

  assign ready_o    = !stage_valid_q || stage_ready_i;
  assign take       = valid_i && ready_o;
  assign v          = data_i.field_value[ValueWidth-1:0];
  assign v_plus_gap = {1'b0, v} + (ValueWidth+1)'(ard_pkg::GapOffset);
  assign top_minus_v = top_q - v;
  assign left_dec   = left_q - ValueWidth'(1);
  assign shift_full = ShiftW'(v) << delay_exponent_i;

  // Frame parser: state update and result for one field
  always_comb begin
    phase_d  = phase_q;
    bottom_d = bottom_q;
    top_d    = top_q;
    left_d   = left_q;
    has_res  = 1'b0;
    stage_d  = '0;
    if (take) begin
      if (data_i.frame_start) begin
        top_d    = v;
        bottom_d = '0;
        left_d   = '0;
        phase_d  = PhDelay;
      end else begin
        unique case (phase_q)
          PhWait: begin
            phase_d = PhWait;
          end
          PhDelay: begin
            has_res           = 1'b1;
            stage_d.kind      = ard_pkg::KindDelay;
            stage_d.shifted   = shift_full[ard_pkg::DelayWidth-1:0];
            stage_d.shift_ovf = |shift_full[ShiftW-1:ard_pkg::DelayWidth];
            phase_d           = PhCount;
          end
          PhCount: begin
            left_d  = v;
            phase_d = PhFirst;
          end
          PhFirst: begin
            has_res = 1'b1;
            if (v > top_q) begin
              stage_d.kind       = ard_pkg::KindError;
              stage_d.error_code = ard_pkg::ErrFirstBlock;
              stage_d.last       = 1'b1;
              phase_d            = PhWait;
            end else begin
              bottom_d           = top_minus_v;
              stage_d.kind       = ard_pkg::KindRange;
              stage_d.range_low  = ard_pkg::FieldWidth'(top_minus_v);
              stage_d.range_high = ard_pkg::FieldWidth'(top_q);
              stage_d.last       = (left_q == '0);
              phase_d            = (left_q == '0) ? PhWait : PhGap;
            end
          end
          PhGap: begin
            if ({1'b0, bottom_q} < v_plus_gap) begin
              has_res            = 1'b1;
              stage_d.kind       = ard_pkg::KindError;
              stage_d.error_code = ard_pkg::ErrLaterRange;
              stage_d.last       = 1'b1;
              phase_d            = PhWait;
            end else begin
              top_d   = bottom_q - v_plus_gap[ValueWidth-1:0];
              phase_d = PhBlock;
            end
          end
          PhBlock: begin
            has_res = 1'b1;
            if (v > top_q) begin
              stage_d.kind       = ard_pkg::KindError;
              stage_d.error_code = ard_pkg::ErrLaterRange;
              stage_d.last       = 1'b1;
              phase_d            = PhWait;
            end else begin
              bottom_d           = top_minus_v;
              left_d             = left_dec;
              stage_d.kind       = ard_pkg::KindRange;
              stage_d.range_low  = ard_pkg::FieldWidth'(top_minus_v);
              stage_d.range_high = ard_pkg::FieldWidth'(top_q);
              stage_d.last       = (left_dec == '0);
              phase_d            = (left_dec == '0) ? PhWait : PhGap;
            end
          end
          default: begin
            phase_d = PhWait;
          end
        endcase
      end
    end
  end

  // Result register toward the scaler; fields without a result leave no entry
  always_comb begin
    if (take) begin
      stage_valid_d = has_res;
    end else begin
      stage_valid_d = stage_valid_q && !stage_ready_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PhWait;
      bottom_q      <= '0;
      top_q         <= '0;
      left_q        <= '0;
      stage_valid_q <= 1'b0;
    end else begin
      phase_q       <= phase_d;
      bottom_q      <= bottom_d;
      top_q         <= top_d;
      left_q        <= left_d;
      stage_valid_q <= stage_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      stage_q <= stage_d;
    end
  end

  assign stage_valid_o = stage_valid_q;
  assign stage_o       = stage_q;

endmodule

[rtl/ard_scale.sv]
module ard_scale (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  ard_pkg::stage_t               stage_i,
  output logic                          ready_o,
  input  logic [ard_pkg::MulWidth-1:0]  time_units_i,
  output logic                          valid_o,
  output ard_pkg::out_t                 data_o,
  input  logic                          stall_i
);

  localparam int ProdW = ard_pkg::HalfWidth + ard_pkg::MulWidth;
  localparam int SumW  = ard_pkg::DelayWidth + ard_pkg::MulWidth + 1;

  typedef struct packed {
    logic [ard_pkg::KindWidth-1:0]  kind;
    logic [ard_pkg::FieldWidth-1:0] range_low;
    logic [ard_pkg::FieldWidth-1:0] range_high;
    logic                           error_code;
    logic                           last;
    logic [ProdW-1:0]               prod_hi;
    logic [ProdW-1:0]               prod_lo;
    logic                           shift_ovf;
  } prod_t;

  logic          prod_valid_q;
  prod_t         prod_q, prod_d;
  logic          out_valid_q;
  ard_pkg::out_t out_q, out_d;
  logic          out_ready;
  logic          prod_take;
  logic          out_take;
  logic [SumW-1:0] sum;

  assign out_ready = !out_valid_q || !stall_i;
  assign ready_o   = !prod_valid_q || out_ready;
  assign prod_take = valid_i && ready_o;
  assign out_take  = prod_valid_q && out_ready;

  // Partial products of the shifted delay, one per 32-bit half
  always_comb begin
    prod_d.kind       = stage_i.kind;
    prod_d.range_low  = stage_i.range_low;
    prod_d.range_high = stage_i.range_high;
    prod_d.error_code = stage_i.error_code;
    prod_d.last       = stage_i.last;
    prod_d.shift_ovf  = stage_i.shift_ovf;
    prod_d.prod_hi    =
        ProdW'(stage_i.shifted[ard_pkg::DelayWidth-1:ard_pkg::HalfWidth]) *
        ProdW'(time_units_i);
    prod_d.prod_lo    = ProdW'(stage_i.shifted[ard_pkg::HalfWidth-1:0]) *
                        ProdW'(time_units_i);
  end

  // Combine the halves and saturate
  assign sum = SumW'({prod_q.prod_hi, ard_pkg::HalfWidth'(0)}) + SumW'(prod_q.prod_lo);

  always_comb begin
    out_d.kind       = prod_q.kind;
    out_d.range_low  = prod_q.range_low;
    out_d.range_high = prod_q.range_high;
    out_d.error_code = prod_q.error_code;
    out_d.last       = prod_q.last;
    if (prod_q.shift_ovf || (|sum[SumW-1:ard_pkg::DelayWidth])) begin
      out_d.ack_delay = '1;
    end else begin
      out_d.ack_delay = sum[ard_pkg::DelayWidth-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      prod_valid_q <= prod_take || (prod_valid_q && !out_ready);
      out_valid_q  <= out_take || (out_valid_q && stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod_take) begin
      prod_q <= prod_d;
    end
    if (out_take) begin
      out_q <= out_d;
    end
  end

  assign valid_o = out_valid_q;
  assign data_o  = out_q;

endmodule

[rtl/ack_range_decoder.sv]
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_stall_o    ard_pkg::in_t   (one frame field)
// out      output     out_valid_o / out_stall_i  ard_pkg::out_t  (delay, range or error)
// cfg      input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One field is taken per cycle while in_stall_o is low. A result passes through
// the input register, frame parser, delay partial products and output
// register with the final add and saturation to 64 bits.
// Reset clears the parser to waiting for a frame start and loads the
// configuration defaults (exponent 3, 1000 units per microsecond).
// A stall on the output holds each stage only while the one behind it is full.
module ack_range_decoder #(
  parameter int ValueWidth = ard_pkg::ValueWidthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  ard_pkg::in_t                      in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output ard_pkg::out_t                     out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ard_pkg::CfgIdxWidth-1:0]   cfg_index_i,
  input  logic [ard_pkg::CfgDataWidth-1:0]  cfg_data_i
);

  logic                          in_valid_q;
  ard_pkg::in_t                  in_q;
  logic                          in_ready;
  logic                          in_take;
  logic                          dec_ready;
  logic                          stage_valid;
  ard_pkg::stage_t               stage;
  logic                          scale_ready;
  logic [ard_pkg::ExpWidth-1:0]  delay_exponent_q;
  logic [ard_pkg::MulWidth-1:0]  time_units_q;

  // Configuration registers, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_exponent_q <= ard_pkg::DelayExponentRst;
      time_units_q     <= ard_pkg::TimeUnitsRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ard_pkg::CfgDelayExponent: delay_exponent_q <= cfg_data_i[ard_pkg::ExpWidth-1:0];
        ard_pkg::CfgTimeUnits:     time_units_q     <= cfg_data_i[ard_pkg::MulWidth-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  assign in_ready   = !in_valid_q || dec_ready;
  assign in_stall_o = !in_ready;
  assign in_take    = in_valid_i && in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_take || (in_valid_q && !dec_ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
  end

  ard_decode #(
    .ValueWidth(ValueWidth)
  ) u_decode (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (in_valid_q),
    .data_i          (in_q),
    .ready_o         (dec_ready),
    .delay_exponent_i(delay_exponent_q),
    .stage_valid_o   (stage_valid),
    .stage_o         (stage),
    .stage_ready_i   (scale_ready)
  );

  ard_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (stage_valid),
    .stage_i     (stage),
    .ready_o     (scale_ready),
    .time_units_i(time_units_q),
    .valid_o     (out_valid_o),
    .data_o      (out_data_o),
    .stall_i     (out_stall_i)
  );

endmodule

[tb/sv/ard_result_check.sv]
`timescale 1ns / 1ps

// Watches the field, result and register channels of the ACK range decoder,
// predicts every result from the fields it accepts, and compares in order.
module ard_result_check (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  ard_pkg::in_t                      in_data_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  ard_pkg::out_t                     out_data_i,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic [ard_pkg::CfgIdxWidth-1:0]   cfg_index_i,
  input  logic [ard_pkg::CfgDataWidth-1:0]  cfg_data_i,
  output int                                fail_count_o,
  output int                                pending_o,
  output int                                delays_o,
  output int                                ranges_o,
  output int                                errors_o
);
  import ard_pkg::*;

  typedef enum logic [2:0] {
    ParseWait, ParseDelay, ParseCount, ParseFirst, ParseGap, ParseBlock
  } parse_e;

  // Predicted decoder state and register copies
  parse_e                parse_q;
  logic [FieldWidth-1:0] bottom_q;
  logic [FieldWidth-1:0] top_q;
  logic [FieldWidth-1:0] left_q;
  logic [ExpWidth-1:0]   exp_q;
  logic [MulWidth-1:0]   mul_q;

  out_t results_due[$];
  int   mismatches;
  int   delays_seen;
  int   ranges_seen;
  int   errors_seen;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  // Delay shifted then scaled; saturates on shift or product overflow
  function automatic logic [DelayWidth-1:0] delay_scaled(input logic [FieldWidth-1:0] raw,
                                                         input logic [ExpWidth-1:0] sh,
                                                         input logic [MulWidth-1:0] mul);
    logic [DelayWidth-1:0]   wide;
    logic [DelayWidth-1:0]   shifted;
    logic [2*DelayWidth-1:0] prod;
    wide = DelayWidth'(raw);
    if (sh != 0 && (wide >> (DelayWidth - sh)) != 0) return '1;
    shifted = wide << sh;
    if (mul == 0) return '0;
    prod = shifted * mul;
    if (prod[2*DelayWidth-1:DelayWidth] != 0) return '1;
    return prod[DelayWidth-1:0];
  endfunction

  task automatic push_range();
    out_t r;
    r = '0;
    r.kind = KindRange;
    r.range_low = bottom_q;
    r.range_high = top_q;
    r.last = (left_q == 0);
    results_due.insert(results_due.size(), r);
    parse_q = r.last ? ParseWait : ParseGap;
  endtask

  task automatic push_error(input logic code);
    out_t r;
    r = '0;
    r.kind = KindError;
    r.error_code = code;
    r.last = 1'b1;
    results_due.insert(results_due.size(), r);
    parse_q = ParseWait;
  endtask

  // One frame field through the predicted parser
  task automatic decode_field(input in_t item);
    out_t                  r;
    logic [FieldWidth-1:0] v;
    v = item.field_value;
    if (item.frame_start) begin
      top_q = v;
      bottom_q = '0;
      left_q = '0;
      parse_q = ParseDelay;
      return;
    end
    case (parse_q)
      ParseDelay: begin
        r = '0;
        r.kind = KindDelay;
        r.ack_delay = delay_scaled(v, exp_q, mul_q);
        results_due.insert(results_due.size(), r);
        parse_q = ParseCount;
      end
      ParseCount: begin
        left_q = v;
        parse_q = ParseFirst;
      end
      ParseFirst: begin
        if (v > top_q) begin
          push_error(ErrFirstBlock);
        end else begin
          bottom_q = top_q - v;
          push_range();
        end
      end
      ParseGap: begin
        if ({2'b00, bottom_q} < {2'b00, v} + 64'(GapOffset)) begin
          push_error(ErrLaterRange);
        end else begin
          top_q = bottom_q - v - FieldWidth'(GapOffset);
          parse_q = ParseBlock;
        end
      end
      ParseBlock: begin
        if (v > top_q) begin
          push_error(ErrLaterRange);
        end else begin
          bottom_q = top_q - v;
          left_q = left_q - FieldWidth'(1);
          push_range();
        end
      end
      default: parse_q = ParseWait;
    endcase
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    if (results_due.size() == 0) begin
      report_mismatch("result with nothing due, kind", 64'(got.kind), '0);
      return;
    end
    want = results_due.pop_front();
    if (got.kind != want.kind)
      report_mismatch("kind", 64'(got.kind), 64'(want.kind));
    if (got.range_low != want.range_low)
      report_mismatch("range_low", 64'(got.range_low), 64'(want.range_low));
    if (got.range_high != want.range_high)
      report_mismatch("range_high", 64'(got.range_high), 64'(want.range_high));
    if (got.ack_delay != want.ack_delay)
      report_mismatch("ack_delay", got.ack_delay, want.ack_delay);
    if (got.error_code != want.error_code)
      report_mismatch("error_code", 64'(got.error_code), 64'(want.error_code));
    if (got.last != want.last)
      report_mismatch("last", 64'(got.last), 64'(want.last));
    case (want.kind)
      KindDelay: delays_seen++;
      KindRange: ranges_seen++;
      default:   errors_seen++;
    endcase
  endtask

  // Compare first: a field taken at this edge cannot have produced a result yet
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      results_due.delete();
      parse_q = ParseWait;
      bottom_q = '0;
      top_q = '0;
      left_q = '0;
      exp_q = DelayExponentRst;
      mul_q = TimeUnitsRst;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CfgDelayExponent) exp_q = cfg_data_i[ExpWidth-1:0];
        else if (cfg_index_i == CfgTimeUnits) mul_q = cfg_data_i[MulWidth-1:0];
      end
      if (out_valid_i && !out_stall_i) check_result(out_data_i);
      if (in_valid_i && !in_stall_i) decode_field(in_data_i);
    end
    fail_count_o <= mismatches;
    pending_o <= results_due.size();
    delays_o <= delays_seen;
    ranges_o <= ranges_seen;
    errors_o <= errors_seen;
  end

  initial begin
    mismatches = 0;
    delays_seen = 0;
    ranges_seen = 0;
    errors_seen = 0;
  end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import ard_pkg::*;

  localparam int ClkHalf     = 5;
  localparam int ResetCycles = 8;
  localparam int CycleLimit  = 100000;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 12;
  localparam int PhaseItems  = 335;
  localparam int NumPhases   = 4;
  localparam logic [FieldWidth-1:0] ValueMax = '1;

  typedef enum int {FlawNone, FlawFirst, FlawGap, FlawBlock, FlawCut, FlawJunk} flaw_e;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  in_t                     in_data_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  out_t                    out_data_o;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CfgIdxWidth-1:0]  cfg_index_i = CfgDelayExponent;
  logic [CfgDataWidth-1:0] cfg_data_i = '0;

  int fail_count;
  int pending;
  int delays_seen;
  int ranges_seen;
  int errors_seen;
  int items_sent = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_seq = 0;
  int hold_done = 0;

  // Per-phase register settings and idle mixes
  int unsigned phase_exp[NumPhases]  = '{0, 31, 20, 7};
  int unsigned phase_mul[NumPhases]  = '{1, 1048575, 1000000, 0};
  int          phase_send[NumPhases] = '{17, 55, 0, 0};
  int          phase_recv[NumPhases] = '{55, 17, 0, 0};

  ack_range_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  ard_result_check u_ack_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .delays_o     (delays_seen),
    .ranges_o     (ranges_seen),
    .errors_o     (errors_seen)
  );

  always begin
    clk_i = 1'b0;
    #(ClkHalf);
    clk_i = 1'b1;
    #(ClkHalf);
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count, pending);
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_seq != hold_done) begin
        repeat (HoldCycles) begin
          out_stall_i <= 1'b1;
          @(posedge clk_i);
        end
        hold_done = hold_seq;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  function automatic logic [FieldWidth-1:0] rand62();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[FieldWidth-1:0];
  endfunction

  // Value in [0, lim], biased toward the ends and small numbers
  function automatic logic [FieldWidth-1:0] pick_upto(input logic [FieldWidth-1:0] lim);
    logic [63:0] span;
    logic [63:0] m;
    span = {2'b00, lim} + 64'd1;
    case ($urandom_range(7))
      0: m = '0;
      1: m = span - 1;
      2: m = (lim > 15) ? span - 1 - $urandom_range(15) : '0;
      3: m = {2'b00, rand62()} % ((span < 64'd41) ? span : 64'd41);
      default: m = {2'b00, rand62()} % span;
    endcase
    return m[FieldWidth-1:0];
  endfunction

  function automatic logic [FieldWidth-1:0] pick_largest();
    case ($urandom_range(5))
      0: return ValueMax;
      1: return FieldWidth'($urandom_range(40));
      2: return FieldWidth'($urandom);
      default: return rand62();
    endcase
  endfunction

  function automatic logic [FieldWidth-1:0] pick_delay();
    case ($urandom_range(5))
      0: return '0;
      1: return ValueMax;
      2: return FieldWidth'($urandom_range(1000));
      3: return FieldWidth'($urandom_range(1 << 20));
      default: return rand62();
    endcase
  endfunction

  // Offer one field and hold it until taken, then maybe idle
  task automatic put_field(input logic [FieldWidth-1:0] v, input logic start);
    in_data_i <= '{field_value: v, frame_start: start};
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Stop offering and let every in-flight field and due result drain
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    repeat (DrainCycles) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic cfg_apply(input logic [CfgDataWidth-1:0] exp_val,
                           input logic [CfgDataWidth-1:0] mul_val);
    cfg_index_i <= CfgDelayExponent;
    cfg_data_i <= exp_val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= CfgTimeUnits;
    cfg_data_i <= mul_val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // One random frame: mostly well formed, some with a bad block or gap,
  // some left open by the next frame start, some trailed by stray fields
  task automatic send_frame();
    logic [FieldWidth-1:0] fields[$];
    logic [FieldWidth-1:0] largest;
    logic [FieldWidth-1:0] fb;
    logic [FieldWidth-1:0] bottom;
    logic [FieldWidth-1:0] top;
    logic [FieldWidth-1:0] gap;
    flaw_e                 flaw;
    int                    r;
    int                    pairs;
    int                    extra;
    int                    cut;
    int                    i;
    r = $urandom_range(99);
    flaw = (r < 70) ? FlawNone : (r < 77) ? FlawFirst : (r < 84) ? FlawGap :
           (r < 91) ? FlawBlock : (r < 96) ? FlawCut : FlawJunk;
    largest = pick_largest();
    fields.insert(fields.size(), largest);
    fields.insert(fields.size(), pick_delay());
    fields.insert(fields.size(), FieldWidth'(0));
    if (flaw == FlawFirst && largest != ValueMax)
      fb = largest + 1'b1 + pick_upto(ValueMax - largest - 1'b1);
    else
      fb = pick_upto(largest);
    fields.insert(fields.size(), fb);
    bottom = largest - fb;
    pairs = 0;
    extra = ($urandom_range(9) == 0) ? $urandom_range(5, 12) : $urandom_range(4);
    while (flaw != FlawFirst && pairs < extra && bottom >= 2) begin
      gap = pick_upto(bottom - GapOffset);
      top = bottom - gap - GapOffset;
      fb = pick_upto(top);
      fields.insert(fields.size(), gap);
      fields.insert(fields.size(), fb);
      bottom = top - fb;
      pairs++;
    end
    if (flaw == FlawBlock && bottom >= 2) begin
      // block above its range top
      gap = pick_upto(bottom - GapOffset);
      top = bottom - gap - GapOffset;
      fields.insert(fields.size(), gap);
      fields.insert(fields.size(), top + 1'b1 + pick_upto(ValueMax - top - 1'b1));
      pairs++;
    end else if (flaw == FlawGap || flaw == FlawBlock) begin
      // gap reaching below packet zero
      if (bottom == 0) gap = pick_upto(ValueMax);
      else gap = bottom - 1'b1 + pick_upto(ValueMax - bottom + 1'b1);
      fields.insert(fields.size(), gap);
      fields.insert(fields.size(), rand62());
      pairs++;
    end
    fields[2] = (flaw == FlawFirst) ? FieldWidth'($urandom_range(3)) : FieldWidth'(pairs);
    if (flaw == FlawCut) begin
      fields[2] = $urandom_range(1) ? rand62() : FieldWidth'(pairs + 1 + $urandom_range(4));
      if ($urandom_range(1)) begin
        cut = $urandom_range(1, fields.size() - 1);
        while (fields.size() > cut) void'(fields.pop_back());
      end
    end
    for (i = 0; i < fields.size(); i++) put_field(fields[i], i == 0);
    if (flaw == FlawJunk || $urandom_range(19) == 0)
      repeat ($urandom_range(1, 3)) put_field(rand62(), 1'b0);
  endtask

  initial begin
    int ph;
    int phase_start;
    bit paused;
    paused = 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset registers: stray field while waiting
    put_field(62'd123, 1'b0);
    // widest frame, shift overflow on the delay, single range with no more to come
    put_field(ValueMax, 1'b1);
    put_field(ValueMax, 1'b0);
    put_field('0, 1'b0);
    put_field('0, 1'b0);
    // packet zero only, then a gap that cannot fit
    put_field('0, 1'b1);
    put_field('0, 1'b0);
    put_field(62'd1, 1'b0);
    put_field('0, 1'b0);
    put_field('0, 1'b0);
    put_field(62'd7, 1'b0);
    // first block above largest acknowledged
    put_field(62'd10, 1'b1);
    put_field(62'd1, 1'b0);
    put_field(62'd2, 1'b0);
    put_field(62'd11, 1'b0);
    // restart mid-frame, product overflow, gap to exactly zero, block above top
    put_field(62'd5, 1'b1);
    put_field(62'd100, 1'b1);
    put_field(62'd1 << 58, 1'b0);
    put_field(62'd1, 1'b0);
    put_field(62'd3, 1'b0);
    put_field(62'd95, 1'b0);
    put_field(62'd1, 1'b0);
    // later block equal to its range top
    put_field(62'd20, 1'b1);
    put_field(62'd250, 1'b0);
    put_field(62'd1, 1'b0);
    put_field(62'd2, 1'b0);
    put_field('0, 1'b0);
    put_field(62'd16, 1'b0);
    wait_quiet();

    // Random frames under each register setting and idle mix
    for (ph = 0; ph < NumPhases; ph++) begin
      cfg_apply(CfgDataWidth'(phase_exp[ph]), CfgDataWidth'(phase_mul[ph]));
      send_idle_pct <= phase_send[ph];
      recv_idle_pct <= phase_recv[ph];
      phase_start = items_sent;
      while (items_sent - phase_start < PhaseItems) begin
        if (ph == 0 && !paused && items_sent - phase_start >= PhaseItems / 2) begin
          wait_quiet();
          paused = 1'b1;
        end
        if (ph == 2 && hold_seq == 0 && items_sent - phase_start >= 60)
          hold_seq <= hold_seq + 1;
        send_frame();
      end
      wait_quiet();
    end

    $display("Decoded %0d fields under %0d register settings: %0d delay, %0d range, %0d error",
             items_sent, NumPhases + 1, delays_seen, ranges_seen, errors_seen);
    $display("results checked, with skewed and no idling, a %0d-cycle output hold and a drain.",
             HoldCycles);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/ard_pkg.sv
rtl/ard_decode.sv
rtl/ard_scale.sv
rtl/ack_range_decoder.sv
tb/sv/ard_result_check.sv
tb/sv/tb_top.sv
